>>> design/mvgf_pkg.sv
// mvgf_pkg: shared constants and controller/datapath handshake structs
// for the missing-value linear gap filler. No dependencies.
`default_nettype none

package mvgf_pkg;

  localparam int GAP_BITS     = 6;
  localparam int CMP_BITS     = GAP_BITS + 1;
  localparam int REG_IDX_BITS = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_MISSING_CODE = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_GAP      = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_FILL_ENDS    = 2'd2;

  localparam logic [GAP_BITS-1:0] MAX_GAP_RESET = 6'd63;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic has_out;
    logic div_done;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> design/mvgf_div.sv
// mvgf_div: iterative floor divider, one quotient bit per cycle.
// Signed numerator, small unsigned divisor; no package dependency.
`default_nettype none

module mvgf_div #(
  parameter int SAMPLE_BITS = 32,
  parameter int MAX_GAP     = 63
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [SAMPLE_BITS:0]           num,
  input  wire logic [$clog2(MAX_GAP+2)-1:0]          den,
  output logic                                       done,
  output logic signed [SAMPLE_BITS+1:0]              quo,
  output logic [$clog2(MAX_GAP+2)-1:0]               rem
);

  localparam int DW   = SAMPLE_BITS + 1;
  localparam int QW   = SAMPLE_BITS + 2;
  localparam int CW   = $clog2(MAX_GAP + 2);
  localparam int CNTW = $clog2(DW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   part;
  logic [DW-1:0]   qsh;
  logic            neg;
  logic [CW-1:0]   dreg;

  logic [DW-1:0]   num_u;
  logic [DW-1:0]   mag;
  logic [CW:0]     trial;
  logic            ge;
  logic [QW-1:0]   q_pos;

  always_comb begin
    num_u = num;
    mag   = num[DW-1] ? (~num_u + DW'(1)) : num_u;
    trial = {part, qsh[DW-1]};
    ge    = trial >= {1'b0, dreg};
    q_pos = {1'b0, qsh};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        part <= '0;
        qsh  <= mag;
        neg  <= num[DW-1];
        dreg <= den;
      end else if (busy) begin
        part <= CW'(ge ? (trial - {1'b0, dreg}) : trial);
        qsh  <= {qsh[DW-2:0], ge};
        cnt  <= cnt + CNTW'(1);
        if (cnt == CNTW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor correction for negative numerators
  always_comb begin
    if (neg && part != '0) begin
      quo = ~q_pos;
      rem = dreg - part;
    end else if (neg) begin
      quo = ~q_pos + QW'(1);
      rem = '0;
    end else begin
      quo = q_pos;
      rem = part;
    end
  end

endmodule

`default_nettype wire

>>> design/mvgf_datapath.sv
// mvgf_datapath: series state, run decode, interpolation stepping and
// the result register. Uses mvgf_pkg and instantiates mvgf_div.
`default_nettype none

module mvgf_datapath
  import mvgf_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int MAX_GAP     = 63
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ctrl_cmd_t                     cmd,
  output dp_status_t                         stat,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          final_sample,
  input  wire logic [SAMPLE_BITS-1:0]        missing_code,
  input  wire logic [GAP_BITS-1:0]           max_gap,
  input  wire logic                          fill_ends,
  input  wire logic                          result_stall,
  output logic                               result_valid,
  output logic signed [SAMPLE_BITS-1:0]      value,
  output logic                               was_filled,
  output logic                               run_overflow,
  output logic                               run_last,
  output logic                               series_last
);

  localparam int SB = SAMPLE_BITS;
  localparam int DW = SAMPLE_BITS + 1;
  localparam int QW = SAMPLE_BITS + 2;
  localparam int CW = $clog2(MAX_GAP + 2);

  typedef enum logic [1:0] {
    MODE_INTERP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_MISS   = 2'd2
  } run_mode_t;

  // series state
  logic signed [SB-1:0] prior_valid, prior_valid_next;
  logic                 have_prior, have_prior_next;
  logic [CW-1:0]        held_run_count, held_run_count_next;
  logic                 run_released, run_released_next;

  // current job
  run_mode_t            mode;
  logic                 ovf;
  logic [CW-1:0]        run_rem;
  logic                 has_tail;
  logic                 fin;
  logic signed [SB-1:0] tailv;
  logic signed [SB-1:0] fillv;
  logic [CW-1:0]        den;
  logic signed [SB-1:0] acc_v;
  logic [CW-1:0]        acc_r;
  logic signed [QW-1:0] q_step;
  logic [CW-1:0]        r_step;

  // decode
  logic                 is_miss, cand, le_gap, held_full;
  run_mode_t            j_mode;
  logic                 j_ovf, j_tail, j_div;
  logic [CW-1:0]        j_cnt;

  // divider
  logic signed [DW-1:0] diff;
  logic                 div_done;
  logic signed [QW-1:0] div_quo;
  logic [CW-1:0]        div_rem;

  // stepping and result select
  logic [CW:0]          r_sum;
  logic                 wrap;
  logic [CW-1:0]        acc_r_n;
  logic [QW-1:0]        v_sum;
  logic signed [SB-1:0] acc_v_n;
  logic signed [SB-1:0] r_value;
  logic                 r_filled, r_ovf, r_last;

  always_comb begin
    is_miss   = $unsigned(sample) == missing_code;
    cand      = fill_ends && have_prior;
    le_gap    = CMP_BITS'(held_run_count) <= CMP_BITS'(max_gap);
    held_full = held_run_count == CW'(MAX_GAP);

    j_mode = MODE_MISS;
    j_ovf  = 1'b0;
    j_cnt  = '0;
    j_tail = 1'b0;
    j_div  = 1'b0;
    prior_valid_next    = prior_valid;
    have_prior_next     = have_prior;
    held_run_count_next = held_run_count;
    run_released_next   = run_released;

    if (!is_miss) begin
      j_tail              = 1'b1;
      prior_valid_next    = sample;
      have_prior_next     = 1'b1;
      held_run_count_next = '0;
      run_released_next   = 1'b0;
      if (!run_released && held_run_count != '0) begin
        j_cnt = held_run_count;
        if (have_prior && le_gap) begin
          j_mode = MODE_INTERP;
          j_div  = 1'b1;
        end else if (!have_prior && fill_ends && le_gap) begin
          j_mode = MODE_FILL;
        end
      end
    end else if (run_released) begin
      j_cnt = CW'(1);
      j_ovf = cand;
    end else if (final_sample) begin
      j_cnt = held_run_count + CW'(1);
      if (cand) begin
        j_mode = MODE_FILL;
      end
    end else if (!held_full) begin
      held_run_count_next = held_run_count + CW'(1);
    end else begin
      // capacity exceeded: release as missing
      j_cnt               = held_run_count + CW'(1);
      j_ovf               = cand;
      held_run_count_next = '0;
      run_released_next   = 1'b1;
    end

    if (final_sample) begin
      prior_valid_next    = '0;
      have_prior_next     = 1'b0;
      held_run_count_next = '0;
      run_released_next   = 1'b0;
    end

    diff = {sample[SB-1], sample} - {prior_valid[SB-1], prior_valid};
  end

  mvgf_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_GAP     (MAX_GAP)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (diff),
    .den   (held_run_count + CW'(1)),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_valid    <= '0;
      have_prior     <= 1'b0;
      held_run_count <= '0;
      run_released   <= 1'b0;
    end else if (cmd.accept) begin
      prior_valid    <= prior_valid_next;
      have_prior     <= have_prior_next;
      held_run_count <= held_run_count_next;
      run_released   <= run_released_next;
    end
  end

  // remainder stepping: k*diff/D = k*q + carries of k*r mod D
  always_comb begin
    r_sum   = {1'b0, acc_r} + {1'b0, r_step};
    wrap    = r_sum >= {1'b0, den};
    acc_r_n = CW'(wrap ? (r_sum - {1'b0, den}) : r_sum);
    v_sum   = {{(QW-SB){acc_v[SB-1]}}, acc_v} + q_step + {{(QW-1){1'b0}}, wrap};
    acc_v_n = v_sum[SB-1:0];

    r_value  = tailv;
    r_filled = 1'b0;
    r_ovf    = 1'b0;
    if (run_rem != '0) begin
      unique case (mode)
        MODE_INTERP: begin
          r_value  = acc_v_n;
          r_filled = 1'b1;
        end
        MODE_FILL: begin
          r_value  = fillv;
          r_filled = 1'b1;
        end
        default: begin
          r_value = missing_code;
          r_ovf   = ovf;
        end
      endcase
    end
    r_last = (run_rem == '0) || (run_rem == CW'(1) && !has_tail);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode     <= j_mode;
      ovf      <= j_ovf;
      run_rem  <= j_cnt;
      has_tail <= j_tail;
      fin      <= final_sample;
      tailv    <= sample;
      fillv    <= is_miss ? prior_valid : sample;
      den      <= held_run_count + CW'(1);
      acc_v    <= prior_valid;
      acc_r    <= '0;
    end else if (cmd.emit && run_rem != '0) begin
      run_rem <= run_rem - CW'(1);
      acc_v   <= acc_v_n;
      acc_r   <= acc_r_n;
    end
    if (div_done) begin
      q_step <= div_quo;
      r_step <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value        <= r_value;
      was_filled   <= r_filled;
      run_overflow <= r_ovf;
      run_last     <= r_last;
      series_last  <= r_last && fin;
    end
  end

  always_comb begin
    stat.need_div  = j_div;
    stat.has_out   = j_tail || (j_cnt != '0);
    stat.div_done  = div_done;
    stat.emit_last = r_last;
    stat.out_free  = !result_valid || !result_stall;
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_run_count <= CW'(MAX_GAP))
    else $error("held run count beyond capacity");

  a_released_empty: assert property (@(posedge clk) disable iff (rst)
    run_released |-> held_run_count == '0)
    else $error("released run still holds samples");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_valid || !result_stall))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

>>> design/mvgf_ctrl.sv
// mvgf_ctrl: one-hot sequencer for accept, divide and result emission.
// Uses mvgf_pkg command and status structs.
`default_nettype none

module mvgf_ctrl
  import mvgf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       sample_valid,
  output logic            sample_stall,
  input  wire dp_status_t stat,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  always_comb begin
    accept        = sample_valid && (state == S_IDLE);
    sample_stall  = state != S_IDLE;
    cmd.accept    = accept;
    cmd.div_start = accept && stat.need_div;
    cmd.emit      = (state == S_EMIT) && stat.out_free;

    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.need_div) begin
            state_next = S_DIV;
          end else if (stat.has_out) begin
            state_next = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.emit && stat.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> state == S_DIV)
    else $error("divide started without entering divide state");

endmodule

`default_nettype wire

>>> design/mvgf_regs.sv
// mvgf_regs: APB-style configuration registers (missing code, max gap,
// end fill). Uses mvgf_pkg register indexes.
`default_nettype none

module mvgf_regs
  import mvgf_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int DATA_BITS   = 32,
  parameter int ADDR_BITS   = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_BITS-1:0]   paddr,
  input  wire logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]        prdata,
  output logic                        pready,
  output logic [SAMPLE_BITS-1:0]      missing_code,
  output logic [GAP_BITS-1:0]         max_gap,
  output logic                        fill_ends
);

  localparam int ADDR_LSB = ADDR_BITS - REG_IDX_BITS;

  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr;

  assign idx    = paddr[ADDR_BITS-1:ADDR_LSB];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_code <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      max_gap      <= MAX_GAP_RESET;
      fill_ends    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_MISSING_CODE: missing_code <= pwdata[SAMPLE_BITS-1:0];
        REG_MAX_GAP:      max_gap      <= pwdata[GAP_BITS-1:0];
        REG_FILL_ENDS:    fill_ends    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MISSING_CODE: prdata = DATA_BITS'(missing_code);
      REG_MAX_GAP:      prdata = DATA_BITS'(max_gap);
      REG_FILL_ENDS:    prdata = DATA_BITS'(fill_ends);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/missing_value_linear_gap_fill.sv
// missing_value_linear_gap_fill: streaming linear gap filler, top level.
// Uses mvgf_pkg; instantiates mvgf_regs, mvgf_ctrl and mvgf_datapath.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------------
//  input    | sample_valid / sample_stall    | sample, final_sample
//  result   | result_valid / result_stall    | value, was_filled, run_overflow,
//           |                                | run_last, series_last
//  config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// A held missing sample produces no result; a valid sample with no open run
// produces one. A closed run of L samples yields L results and then the closing
// sample, after the bit-serial floor divider when the run is interpolated.
// Results leave one beat per cycle from the result register while the result
// channel is not stalled; the next beat of input is taken once the last result
// of the current beat is loaded there. Synchronous reset, no clearing pass.
`default_nettype none

module missing_value_linear_gap_fill
  import mvgf_pkg::*;
#(
  parameter int MAX_GAP     = 63,
  parameter int SAMPLE_BITS = 32,
  localparam int DATA_BITS  = (SAMPLE_BITS > 32) ? 64 : 32,
  localparam int ADDR_BITS  = ((SAMPLE_BITS > 32) ? 3 : 2) + REG_IDX_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          final_sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0]      value,
  output logic                               was_filled,
  output logic                               run_overflow,
  output logic                               run_last,
  output logic                               series_last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_BITS-1:0]          paddr,
  input  wire logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]               prdata,
  output logic                               pready
);

  logic [SAMPLE_BITS-1:0] missing_code;
  logic [GAP_BITS-1:0]    max_gap;
  logic                   fill_ends;
  ctrl_cmd_t              cmd;
  dp_status_t             stat;

  mvgf_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DATA_BITS   (DATA_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .missing_code (missing_code),
    .max_gap      (max_gap),
    .fill_ends    (fill_ends)
  );

  mvgf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  mvgf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_GAP     (MAX_GAP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .final_sample (final_sample),
    .missing_code (missing_code),
    .max_gap      (max_gap),
    .fill_ends    (fill_ends),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .value        (value),
    .was_filled   (was_filled),
    .run_overflow (run_overflow),
    .run_last     (run_last),
    .series_last  (series_last)
  );

endmodule

`default_nettype wire
